/* hdl/rau_pkg.sv */
// Shared types, codes and helpers for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam logic [31:0] WORD_MASK = 32'((64'd1 << WORD_BITS) - 64'd1);
  localparam logic [63:0] WORD_LIM  = (64'd1 << (WORD_BITS - 1)) - 64'd1;

  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_SUB   = 3'd1;
  localparam logic [2:0] MODE_MUL   = 3'd2;
  localparam logic [2:0] MODE_DIV   = 3'd3;
  localparam logic [2:0] MODE_LESS  = 3'd4;
  localparam logic [2:0] MODE_EQUAL = 3'd5;
  localparam logic [2:0] MODE_NEG   = 3'd6;
  localparam logic [2:0] MODE_INV   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_flag;
    logic [1:0]         status;
  } rau_out_t;

  typedef enum logic [1:0] {
    EOP_GCD,
    EOP_DIV,
    EOP_MUL
  } eng_op_t;

  typedef struct packed {
    logic        start;
    eng_op_t     op;
    logic [63:0] x;
    logic [63:0] y;
  } eng_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } eng_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RG, S_RN, S_RD, S_RET, S_MODE, S_CHECK,
    S_AG, S_AT1, S_AT2, S_AP1, S_AP2, S_AP3, S_AC,
    S_MG1, S_MG2, S_MQ1, S_MQ2, S_MQ3, S_MQ4, S_MP1, S_MP2,
    S_LP1, S_LP2, S_LC
  } rau_state_t;

  typedef enum logic [1:0] {
    RET_A,
    RET_B,
    RET_R
  } rau_ret_t;

  // Sign of a word taken as WORD_BITS-bit two's complement.
  function automatic logic word_sign(logic [31:0] v);
    return v[WORD_BITS-1];
  endfunction

  // Magnitude of a word taken as WORD_BITS-bit two's complement.
  function automatic logic [31:0] word_mag(logic [31:0] v);
    logic [31:0] w;
    w = v & WORD_MASK;
    if (v[WORD_BITS-1]) w = w | ~WORD_MASK;
    return w[31] ? (32'd0 - w) : w;
  endfunction

endpackage
`default_nettype wire

/* hdl/rau_engine.sv */
// Shared engine: binary gcd, 64-bit restoring divide, 32x32 multiply.
`default_nettype none
module rau_engine import rau_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire eng_req_t req,
  output eng_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  eng_op_t     op_r, op_nxt;
  logic [63:0] u_r, u_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] res_r, res_nxt;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic        qbit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    rem_r <= rem_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rem_sh  = {rem_r, u_r[63]};
  assign rem_sub = rem_sh - {1'b0, v_r};
  assign qbit    = (rem_sh >= {1'b0, v_r});

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    if (!busy_r) begin
      if (req.start) begin
        op_nxt  = req.op;
        u_nxt   = req.x;
        v_nxt   = req.y;
        rem_nxt = '0;
        k_nxt   = '0;
        cnt_nxt = '0;
        if (req.op == EOP_MUL) begin
          res_nxt  = 64'(req.x[31:0]) * 64'(req.y[31:0]);
          done_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b1;
        end
      end
    end else begin
      unique case (op_r)
        EOP_GCD: begin
          priority if (u_r == 64'd0 || v_r == 64'd0) begin
            res_nxt  = (u_r | v_r) << k_r;
            done_nxt = 1'b1;
            busy_nxt = 1'b0;
          end else if (!u_r[0] && !v_r[0]) begin
            u_nxt = u_r >> 1;
            v_nxt = v_r >> 1;
            k_nxt = k_r + 6'd1;
          end else if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else if (u_r >= v_r) begin
            u_nxt = (u_r - v_r) >> 1;
          end else begin
            v_nxt = (v_r - u_r) >> 1;
          end
        end
        EOP_DIV: begin
          // shift one dividend bit into the remainder, quotient bit into u
          if (qbit) rem_nxt = rem_sub[63:0];
          else      rem_nxt = rem_sh[63:0];
          u_nxt   = {u_r[62:0], qbit};
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            res_nxt  = {u_r[62:0], qbit};
            done_nxt = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

/* hdl/rational_arith_unit_core.sv */
// Top level: sequencer that runs rational arithmetic on the shared engine.
//
//   channel | ports                         | handshake
//   input   | start, busy, in_item          | taken when start && !busy
//   result  | out_valid, out_item           | one-cycle strobe, no backpressure
//
// An item with a zero denominator is answered without busy rising; any other
// item runs, for each operand and result reduction, a binary gcd (one step
// per cycle) and two restoring divisions on the single engine.
// busy stays high from acceptance until the cycle the result strobes.
// rst_n is synchronous; it returns the sequencer and engine to idle.
`default_nettype none
module rational_arith_unit_core import rau_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire rau_in_t in_item,
  output logic         out_valid,
  output rau_out_t     out_item
);

  rau_state_t  state_r, state_nxt;
  rau_ret_t    ret_r, ret_nxt;
  logic        issued_r, issued_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] am_r, am_nxt, ad_r, ad_nxt, bm_r, bm_nxt, bd_r, bd_nxt;
  logic        aneg_r, aneg_nxt, bneg_r, bneg_nxt, neg_r, neg_nxt;
  logic [63:0] wm_r, wm_nxt, wd_r, wd_nxt, g1_r, g1_nxt, g2_r, g2_nxt;
  logic        out_valid_r, out_valid_nxt;
  rau_out_t    out_r, out_nxt;
  eng_req_t    req;
  eng_rsp_t    rsp;
  logic        run;
  logic        in_uses_b;
  logic        rneg;
  logic [63:0] nlim;

  rau_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ret_r  <= ret_nxt;
    mode_r <= mode_nxt;
    am_r   <= am_nxt;
    ad_r   <= ad_nxt;
    bm_r   <= bm_nxt;
    bd_r   <= bd_nxt;
    aneg_r <= aneg_nxt;
    bneg_r <= bneg_nxt;
    neg_r  <= neg_nxt;
    wm_r   <= wm_nxt;
    wd_r   <= wd_nxt;
    g1_r   <= g1_nxt;
    g2_r   <= g2_nxt;
    out_r  <= out_nxt;
  end

  assign in_uses_b = (in_item.mode < MODE_NEG);
  assign rneg      = neg_r && (wm_r != 64'd0);
  assign nlim      = neg_r ? (WORD_LIM + 64'd1) : WORD_LIM;

  // engine operand select
  always_comb begin
    run    = 1'b1;
    req.op = EOP_GCD;
    req.x  = '0;
    req.y  = '0;
    unique case (state_r)
      S_RG:  begin req.op = EOP_GCD; req.x = wm_r; req.y = wd_r; end
      S_RN:  begin req.op = EOP_DIV; req.x = wm_r; req.y = g1_r; end
      S_RD:  begin req.op = EOP_DIV; req.x = wd_r; req.y = g1_r; end
      S_AG:  begin req.op = EOP_GCD; req.x = 64'(ad_r); req.y = 64'(bd_r); end
      S_AT1: begin req.op = EOP_DIV; req.x = 64'(ad_r); req.y = g1_r; end
      S_AT2: begin req.op = EOP_DIV; req.x = 64'(bd_r); req.y = g1_r; end
      S_AP1: begin req.op = EOP_MUL; req.x = g2_r; req.y = 64'(bd_r); end
      S_AP2: begin req.op = EOP_MUL; req.x = 64'(am_r); req.y = g1_r; end
      S_AP3: begin req.op = EOP_MUL; req.x = 64'(bm_r); req.y = g2_r; end
      S_MG1: begin req.op = EOP_GCD; req.x = 64'(am_r); req.y = 64'(bd_r); end
      S_MG2: begin req.op = EOP_GCD; req.x = 64'(bm_r); req.y = 64'(ad_r); end
      S_MQ1: begin req.op = EOP_DIV; req.x = 64'(am_r); req.y = g1_r; end
      S_MQ2: begin req.op = EOP_DIV; req.x = 64'(bm_r); req.y = g2_r; end
      S_MQ3: begin req.op = EOP_DIV; req.x = 64'(ad_r); req.y = g2_r; end
      S_MQ4: begin req.op = EOP_DIV; req.x = 64'(bd_r); req.y = g1_r; end
      S_MP1: begin req.op = EOP_MUL; req.x = 64'(am_r); req.y = 64'(bm_r); end
      S_MP2: begin req.op = EOP_MUL; req.x = 64'(ad_r); req.y = 64'(bd_r); end
      S_LP1: begin req.op = EOP_MUL; req.x = 64'(am_r); req.y = 64'(bd_r); end
      S_LP2: begin req.op = EOP_MUL; req.x = 64'(bm_r); req.y = 64'(ad_r); end
      default: run = 1'b0;
    endcase
    req.start = run && !issued_r;
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    issued_nxt    = issued_r;
    mode_nxt      = mode_r;
    am_nxt        = am_r;
    ad_nxt        = ad_r;
    bm_nxt        = bm_r;
    bd_nxt        = bd_r;
    aneg_nxt      = aneg_r;
    bneg_nxt      = bneg_r;
    neg_nxt       = neg_r;
    wm_nxt        = wm_r;
    wd_nxt        = wd_r;
    g1_nxt        = g1_r;
    g2_nxt        = g2_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (run) begin
      if (!issued_r) begin
        issued_nxt = 1'b1;
      end else if (rsp.done) begin
        issued_nxt = 1'b0;
        unique case (state_r)
          S_RG:  begin g1_nxt = rsp.res; state_nxt = S_RN; end
          S_RN:  begin wm_nxt = rsp.res; state_nxt = S_RD; end
          S_RD:  begin wd_nxt = rsp.res; state_nxt = S_RET; end
          S_AG:  begin g1_nxt = rsp.res; state_nxt = S_AT1; end
          S_AT1: begin g2_nxt = rsp.res; state_nxt = S_AT2; end
          S_AT2: begin g1_nxt = rsp.res; state_nxt = S_AP1; end
          S_AP1: begin wd_nxt = rsp.res; state_nxt = S_AP2; end
          S_AP2: begin wm_nxt = rsp.res; state_nxt = S_AP3; end
          S_AP3: begin g1_nxt = rsp.res; state_nxt = S_AC; end
          S_MG1: begin g1_nxt = rsp.res; state_nxt = S_MG2; end
          S_MG2: begin g2_nxt = rsp.res; state_nxt = S_MQ1; end
          S_MQ1: begin am_nxt = rsp.res[31:0]; state_nxt = S_MQ2; end
          S_MQ2: begin bm_nxt = rsp.res[31:0]; state_nxt = S_MQ3; end
          S_MQ3: begin ad_nxt = rsp.res[31:0]; state_nxt = S_MQ4; end
          S_MQ4: begin bd_nxt = rsp.res[31:0]; state_nxt = S_MP1; end
          S_MP1: begin wm_nxt = rsp.res; state_nxt = S_MP2; end
          S_MP2: begin
            wd_nxt    = rsp.res;
            neg_nxt   = aneg_r ^ bneg_r;
            ret_nxt   = RET_R;
            state_nxt = S_RG;
          end
          S_LP1: begin wm_nxt = rsp.res; state_nxt = S_LP2; end
          S_LP2: begin g1_nxt = rsp.res; state_nxt = S_LC; end
          default: state_nxt = S_IDLE;
        endcase
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_nxt = in_item.mode;
            out_nxt  = '{res_num: '0, res_den: '0, compare_flag: 1'b0, status: ST_OK};
            if (word_mag(in_item.a_den) == 32'd0 ||
                (in_uses_b && word_mag(in_item.b_den) == 32'd0)) begin
              out_nxt.status = ST_ZERO_DEN;
              out_valid_nxt  = 1'b1;
            end else begin
              wm_nxt    = 64'(word_mag(in_item.a_num));
              wd_nxt    = 64'(word_mag(in_item.a_den));
              neg_nxt   = word_sign(in_item.a_num) ^ word_sign(in_item.a_den);
              bm_nxt    = word_mag(in_item.b_num);
              bd_nxt    = word_mag(in_item.b_den);
              bneg_nxt  = word_sign(in_item.b_num) ^ word_sign(in_item.b_den);
              ret_nxt   = RET_A;
              state_nxt = S_RG;
            end
          end
        end
        S_RET: begin
          unique case (ret_r)
            RET_A: begin
              am_nxt   = wm_r[31:0];
              ad_nxt   = wd_r[31:0];
              aneg_nxt = rneg;
              if (mode_r < MODE_NEG) begin
                wm_nxt    = 64'(bm_r);
                wd_nxt    = 64'(bd_r);
                neg_nxt   = bneg_r;
                ret_nxt   = RET_B;
                state_nxt = S_RG;
              end else begin
                state_nxt = S_MODE;
              end
            end
            RET_B: begin
              bm_nxt    = wm_r[31:0];
              bd_nxt    = wd_r[31:0];
              bneg_nxt  = rneg;
              state_nxt = S_MODE;
            end
            default: begin
              neg_nxt   = rneg;
              state_nxt = S_CHECK;
            end
          endcase
        end
        S_MODE: begin
          unique case (mode_r)
            MODE_ADD: state_nxt = S_AG;
            MODE_SUB: begin
              bneg_nxt  = (bm_r != 32'd0) && !bneg_r;
              state_nxt = S_AG;
            end
            MODE_MUL: state_nxt = S_MG1;
            MODE_DIV: begin
              if (bm_r == 32'd0) begin
                out_nxt.status = ST_DIV_ZERO;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_IDLE;
              end else begin
                // multiply by the reciprocal of b
                bm_nxt    = bd_r;
                bd_nxt    = bm_r;
                state_nxt = S_MG1;
              end
            end
            MODE_LESS: state_nxt = S_LP1;
            MODE_EQUAL: begin
              out_nxt.res_den      = 31'd1;
              out_nxt.compare_flag = (aneg_r == bneg_r) && (am_r == bm_r) && (ad_r == bd_r);
              out_valid_nxt        = 1'b1;
              state_nxt            = S_IDLE;
            end
            MODE_NEG: begin
              wm_nxt    = 64'(am_r);
              wd_nxt    = 64'(ad_r);
              neg_nxt   = !aneg_r && (am_r != 32'd0);
              state_nxt = S_CHECK;
            end
            default: begin
              if (am_r == 32'd0) begin
                out_nxt.status = ST_DIV_ZERO;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_IDLE;
              end else begin
                wm_nxt    = 64'(ad_r);
                wd_nxt    = 64'(am_r);
                neg_nxt   = aneg_r;
                state_nxt = S_CHECK;
              end
            end
          endcase
        end
        S_AC: begin
          priority if (aneg_r == bneg_r) begin
            wm_nxt  = wm_r + g1_r;
            neg_nxt = aneg_r;
          end else if (wm_r >= g1_r) begin
            wm_nxt  = wm_r - g1_r;
            neg_nxt = aneg_r;
          end else begin
            wm_nxt  = g1_r - wm_r;
            neg_nxt = bneg_r;
          end
          ret_nxt   = RET_R;
          state_nxt = S_RG;
        end
        S_LC: begin
          out_nxt.res_den      = 31'd1;
          out_nxt.compare_flag = (aneg_r && !bneg_r) ||
                                 (!aneg_r && !bneg_r && (wm_r < g1_r)) ||
                                 (aneg_r && bneg_r && (wm_r > g1_r));
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
        S_CHECK: begin
          if (wd_r > WORD_LIM || wm_r > nlim) begin
            out_nxt.status = ST_OVERFLOW;
          end else begin
            out_nxt.res_num = 32'(neg_r ? (64'd0 - wm_r) : wm_r);
            out_nxt.res_den = wd_r[30:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

/* hdl/rau_checker.sv */
// Port-level checks for the rational arithmetic unit, bound to the top level.
`default_nettype none
module rau_checker import rau_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire rau_in_t  in_item,
  input wire logic     out_valid,
  input wire rau_out_t out_item
);

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_item.a_den == 32'sd0)) |=> (busy || out_valid))
    else $error("accepted item neither worked on nor answered");

  a_error_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.res_num == 32'sd0 && out_item.res_den == 31'd0 &&
       !out_item.compare_flag))
    else $error("error result carries data");

  a_flag_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.compare_flag) |->
      (out_item.res_den == 31'd1 && out_item.status == ST_OK &&
       out_item.res_num == 32'sd0))
    else $error("compare result malformed");

endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
